[src/tlpt_pkg.sv]
`default_nettype none

package tlpt_pkg;

  localparam int unsigned SECTION_COUNT     = 4096;
  localparam int unsigned PAGES_PER_SECTION = 256;

  // section index bits of the stores, and of a full 32-bit address
  localparam int unsigned SEC_W      = (SECTION_COUNT > 1) ? $clog2(SECTION_COUNT) : 1;
  localparam int unsigned SLOT_W     = $clog2(PAGES_PER_SECTION);
  localparam int unsigned VA_SEC_W   = 12;
  localparam int unsigned SEC_CMP_W  = VA_SEC_W + 1;
  localparam int unsigned DESC_DEPTH = SECTION_COUNT * PAGES_PER_SECTION;

  // up to 2^20 pages for a full 4 GB region
  localparam int unsigned PAGE_CNT_W  = 21;
  localparam int unsigned UNMAP_CNT_W = 12;

  localparam logic [SEC_CMP_W-1:0] SEC_LIMIT  = SEC_CMP_W'(SECTION_COUNT);
  localparam logic [SEC_W-1:0]     SEC_LAST   = SEC_W'(SECTION_COUNT - 1);
  localparam logic [31:0]          FRAME_MASK = 32'hFFFF_F000;
  localparam logic [31:0]          SMALL_PAGE = 32'h0000_0002;
  localparam logic [31:0]          PAGE_BYTES = 32'h0000_1000;

  typedef enum logic [1:0] {
    KIND_MAP    = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_UNMAP  = 2'd2
  } kind_e;

  typedef struct packed {
    logic load;        // capture the input beat
    logic init_wr;     // post-reset sweep of the section types
    logic type_rd;     // read section type at the current page
    logic desc_rd;     // read descriptor at the current page
    logic set_coarse;  // mark current section coarse
    logic clr_wr;      // zero one descriptor of the current section
    logic page_wr;     // write descriptor, step to next page
    logic page_skip;   // step to next page without a write
    logic unmap_wr;    // mark one section unmapped, step on
    logic finish;      // emit the result beat
    logic lookup_res;  // result is the translation, else zero
  } tlpt_cmd_t;

  typedef struct packed {
    logic init_last;
    logic pages_zero;
    logic page_in_range;
    logic sec_coarse;
    logic clr_last;
    logic unmap_done;
  } tlpt_stat_t;

endpackage

`default_nettype wire

[src/two_level_page_table_engine_top.sv]
`default_nettype none

// Two-level page table engine: per-section type plus 256 small-page
// descriptors per 1 MB section.
// Command channel: a beat is taken on the rising edge where start_i is high
//   and busy_o is low; kind_i selects map (0), lookup (1) or unmap (2).
// Result channel: done_o pulses for one cycle with result_addr_o; every
//   command gives exactly one result beat. The receiver cannot stall, and
//   a new command may be taken in the cycle the result is shown.
// Work per command, from accept to result strobe:
//   lookup       registered reads of both stores, then the result
//   map          per page a section type read, then the descriptor write;
//                a section not yet coarse is first cleared (256 entries)
//   unmap        one section per step, floor(length / 1 MB) at most
//   unknown kind zero result, no walk
//   Sustained rate is set by the page walk and the section clear loop,
//   both through the single write port of the descriptor memory.
// Reset: busy_o stays high while all SECTION_COUNT (4096) entries of the
//   section type store are swept to unmapped. Descriptors are not
//   swept: unmapped sections map to frame zero, cleared on conversion.
module two_level_page_table_engine_top
  import tlpt_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [1:0]  kind_i,
  input  wire logic [31:0] virt_addr_i,
  input  wire logic [31:0] phys_addr_i,
  input  wire logic [31:0] length_i,
  input  wire logic [11:0] attrs_i,
  output logic             done_o,
  output logic [31:0]      result_addr_o
);

  tlpt_cmd_t  cmd;
  tlpt_stat_t stat;

  // sequencer: walk control, one command set per cycle
  tlpt_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .kind_i  (kind_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  // stores, address counters and result register
  tlpt_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .virt_addr_i   (virt_addr_i),
    .phys_addr_i   (phys_addr_i),
    .length_i      (length_i),
    .attrs_i       (attrs_i),
    .done_o        (done_o),
    .result_addr_o (result_addr_o)
  );

endmodule

`default_nettype wire

[src/tlpt_ctrl.sv]
`default_nettype none

module tlpt_ctrl
  import tlpt_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  input  wire logic [1:0] kind_i,
  input  wire tlpt_stat_t stat_i,
  output tlpt_cmd_t       cmd_o,
  output logic            busy_o
);

  typedef enum logic [8:0] {
    S_INIT    = 9'b0_0000_0001,
    S_IDLE    = 9'b0_0000_0010,
    S_MAP_RD  = 9'b0_0000_0100,
    S_MAP_CHK = 9'b0_0000_1000,
    S_MAP_CLR = 9'b0_0001_0000,
    S_MAP_WR  = 9'b0_0010_0000,
    S_LK_RD   = 9'b0_0100_0000,
    S_LK_RES  = 9'b0_1000_0000,
    S_UNMAP   = 9'b1_0000_0000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_INIT: begin
        cmd_o.init_wr = 1'b1;
        if (stat_i.init_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          case (kind_e'(kind_i))
            KIND_MAP:    state_d = S_MAP_RD;
            KIND_LOOKUP: state_d = S_LK_RD;
            KIND_UNMAP:  state_d = S_UNMAP;
            default:     cmd_o.finish = 1'b1;  // unknown kind: zero result
          endcase
        end
      end
      S_MAP_RD: begin
        if (stat_i.pages_zero) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end else if (!stat_i.page_in_range) begin
          cmd_o.page_skip = 1'b1;
        end else begin
          cmd_o.type_rd = 1'b1;
          state_d       = S_MAP_CHK;
        end
      end
      S_MAP_CHK: begin
        if (stat_i.sec_coarse) begin
          cmd_o.page_wr = 1'b1;
          state_d       = S_MAP_RD;
        end else begin
          cmd_o.set_coarse = 1'b1;
          state_d          = S_MAP_CLR;
        end
      end
      S_MAP_CLR: begin
        cmd_o.clr_wr = 1'b1;
        if (stat_i.clr_last) begin
          state_d = S_MAP_WR;
        end
      end
      S_MAP_WR: begin
        cmd_o.page_wr = 1'b1;
        state_d       = S_MAP_RD;
      end
      S_LK_RD: begin
        cmd_o.type_rd = 1'b1;
        cmd_o.desc_rd = 1'b1;
        state_d       = S_LK_RES;
      end
      S_LK_RES: begin
        cmd_o.finish     = 1'b1;
        cmd_o.lookup_res = 1'b1;
        state_d          = S_IDLE;
      end
      S_UNMAP: begin
        if (stat_i.unmap_done) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end else begin
          cmd_o.unmap_wr = 1'b1;
        end
      end
      default: begin
        state_d = S_INIT;
      end
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

`default_nettype wire

[src/tlpt_dp.sv]
`default_nettype none

module tlpt_dp
  import tlpt_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire tlpt_cmd_t   cmd_i,
  output tlpt_stat_t       stat_o,
  input  wire logic [31:0] virt_addr_i,
  input  wire logic [31:0] phys_addr_i,
  input  wire logic [31:0] length_i,
  input  wire logic [11:0] attrs_i,
  output logic             done_o,
  output logic [31:0]      result_addr_o
);

  localparam int unsigned DESC_AW = SEC_W + SLOT_W;

  // section type store: 1 = coarse, 0 = unmapped
  logic coarse_mem [SECTION_COUNT];
  logic [31:0] desc_mem [DESC_DEPTH];

  logic [31:0]             va_q, pa_q;
  logic [11:0]             attrs_q;
  logic [PAGE_CNT_W-1:0]   pages_q;
  logic [SEC_CMP_W-1:0]    unmap_sec_q;
  logic [UNMAP_CNT_W-1:0]  unmap_cnt_q;
  logic [SEC_W-1:0]        init_cnt_q;
  logic [SLOT_W-1:0]       clr_cnt_q;
  logic                    coarse_rd_q;
  logic [31:0]             desc_rd_q;
  logic                    in_range_q;
  logic                    done_q;
  logic [31:0]             result_q;

  logic [32:0]             len_round;
  logic                    page_in_range;
  logic [SEC_W-1:0]        page_sec;
  logic [DESC_AW-1:0]      page_idx;
  logic [DESC_AW-1:0]      desc_waddr;
  logic [31:0]             desc_wdata;
  logic [31:0]             page_desc;
  logic                    type_we;
  logic [SEC_W-1:0]        type_waddr;
  logic                    type_wdata;
  logic [31:0]             lookup_addr;

  assign len_round     = {1'b0, length_i} + 33'(PAGE_BYTES - 32'd1);
  assign page_in_range = {1'b0, va_q[31:20]} < SEC_LIMIT;
  assign page_sec      = va_q[20 +: SEC_W];
  assign page_idx      = {page_sec, va_q[12 +: SLOT_W]};
  assign page_desc     = (pa_q & FRAME_MASK) | {20'd0, attrs_q} | SMALL_PAGE;

  // beat capture, page / section walk counters
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      va_q        <= virt_addr_i;
      pa_q        <= phys_addr_i;
      attrs_q     <= attrs_i;
      pages_q     <= len_round[32:12];
      unmap_sec_q <= {1'b0, virt_addr_i[31:20]};
      unmap_cnt_q <= length_i[31:20];
    end else begin
      if (cmd_i.page_wr || cmd_i.page_skip) begin
        va_q    <= va_q + PAGE_BYTES;
        pa_q    <= pa_q + PAGE_BYTES;
        pages_q <= pages_q - PAGE_CNT_W'(1);
      end
      if (cmd_i.unmap_wr) begin
        unmap_sec_q <= unmap_sec_q + SEC_CMP_W'(1);
        unmap_cnt_q <= unmap_cnt_q - UNMAP_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_cnt_q <= '0;
      clr_cnt_q  <= '0;
      done_q     <= 1'b0;
    end else begin
      if (cmd_i.init_wr) begin
        init_cnt_q <= init_cnt_q + SEC_W'(1);
      end
      if (cmd_i.clr_wr) begin
        clr_cnt_q <= clr_cnt_q + SLOT_W'(1);  // wraps back to zero at the end
      end
      done_q <= cmd_i.finish;
    end
  end

  // section type store
  always_comb begin
    type_we    = cmd_i.init_wr || cmd_i.set_coarse || cmd_i.unmap_wr;
    type_wdata = cmd_i.set_coarse;
    if (cmd_i.init_wr) begin
      type_waddr = init_cnt_q;
    end else if (cmd_i.set_coarse) begin
      type_waddr = page_sec;
    end else begin
      type_waddr = unmap_sec_q[SEC_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (type_we) begin
      coarse_mem[type_waddr] <= type_wdata;
    end
    if (cmd_i.type_rd) begin
      coarse_rd_q <= coarse_mem[page_sec];
      in_range_q  <= page_in_range;
    end
  end

  // descriptor store; unmapped sections masked on read, cleared on conversion
  assign desc_waddr = cmd_i.clr_wr ? {page_sec, clr_cnt_q} : page_idx;
  assign desc_wdata = cmd_i.clr_wr ? 32'd0 : page_desc;

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_wr || cmd_i.page_wr) begin
      desc_mem[desc_waddr] <= desc_wdata;
    end
    if (cmd_i.desc_rd) begin
      desc_rd_q <= desc_mem[page_idx];
    end
  end

  assign lookup_addr = (in_range_q && coarse_rd_q)
                     ? ((desc_rd_q & FRAME_MASK) | {20'd0, va_q[11:0]})
                     : {20'd0, va_q[11:0]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      result_q <= cmd_i.lookup_res ? lookup_addr : 32'd0;
    end
  end

  assign stat_o.init_last     = (init_cnt_q == SEC_LAST);
  assign stat_o.pages_zero    = (pages_q == '0);
  assign stat_o.page_in_range = page_in_range;
  assign stat_o.sec_coarse    = coarse_rd_q;
  assign stat_o.clr_last      = &clr_cnt_q;
  assign stat_o.unmap_done    = (unmap_cnt_q == '0) || (unmap_sec_q >= SEC_LIMIT);

  assign done_o        = done_q;
  assign result_addr_o = result_q;

endmodule

`default_nettype wire
